// File: src/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared widths, register indexes, types and small tables for the 3x3 box
// mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  // Pixel and configuration widths
  localparam int PIX_W     = 16;
  localparam int CFG_W     = 11;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Reset value of both frame dimensions
  localparam logic [CFG_W-1:0] DIM_RESET = 11'd9;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Arithmetic widths: a column sum of three pixels, a window sum of nine
  // pixels plus the rounding half, and the neighbour count (at most nine).
  localparam int CS_W     = PIX_W + 2;
  localparam int SUM_W    = PIX_W + 4;
  localparam int N_W      = 4;
  localparam int RECIP_SH = SUM_W;
  localparam int RECIP_W  = RECIP_SH + 1;

  // One column of the window: two lines from the line memory and the new pixel.
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } pix_col_t;

  // Per-pixel window control worked out when the pixel is taken.
  typedef struct packed {
    logic emit;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } win_ctl_t;

  // Tag that travels with a sum through the divider.
  typedef struct packed {
    logic vld;
    logic last;
  } div_tag_t;

  // Zero becomes one, anything above the limit is saturated to the limit.
  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if ({{(32-CFG_W){1'b0}}, v} > maxv) begin
      res = CFG_W'(maxv);
    end
    return res;
  endfunction

  // floor(2^RECIP_SH / n) for every neighbour count that can occur.
  function automatic logic [RECIP_W-1:0] recip_of(logic [N_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd1);
      4'd2:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd2);
      4'd3:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd3);
      4'd4:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd4);
      4'd6:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd6);
      4'd9:    r = RECIP_W'((64'd1 << RECIP_SH) / 64'd9);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: src/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. A read of the address being written returns the old data.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage array and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/bmf_div.sv
// ----------------------------------------------------------------------------
// bmf_div
// Two-stage division of the rounded window sum by the neighbour count,
// using a reciprocal multiply followed by a single correction step.
// ----------------------------------------------------------------------------
module bmf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  bmf_pkg::div_tag_t           in_tag,
  input  logic [bmf_pkg::SUM_W-1:0]   in_t,
  input  logic [bmf_pkg::N_W-1:0]     in_n,
  output bmf_pkg::div_tag_t           out_tag,
  output logic [bmf_pkg::PIX_W-1:0]   out_q
);

  import bmf_pkg::*;

  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int QN_W   = SUM_W + N_W + 1;

  logic              a_vld_r;
  logic              a_last_r;
  logic [SUM_W-1:0]  a_t_r;
  logic [N_W-1:0]    a_n_r;
  logic              b_vld_r;
  logic              b_last_r;
  logic [SUM_W-1:0]  b_q_r;
  logic [SUM_W-1:0]  b_t_r;
  logic [N_W-1:0]    b_n_r;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  q_inc;
  logic [QN_W-1:0]   qn1;
  logic [SUM_W-1:0]  q;

  // Estimate of the quotient; it is exact or one short.
  assign prod = PROD_W'(a_t_r) * PROD_W'(recip_of(a_n_r));

  // Valid bits of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tag.vld;
      b_vld_r <= a_vld_r;
    end
  end

  // Operands and the registered estimate
  always_ff @(posedge clk) begin
    if (en) begin
      a_last_r <= in_tag.last;
      a_t_r    <= in_t;
      a_n_r    <= in_n;
      b_last_r <= a_last_r;
      b_q_r    <= prod[RECIP_SH +: SUM_W];
      b_t_r    <= a_t_r;
      b_n_r    <= a_n_r;
    end
  end

  // Correction: step the quotient up when one more multiple still fits.
  assign q_inc = b_q_r + SUM_W'(1);
  assign qn1   = QN_W'(q_inc) * QN_W'(b_n_r);
  assign q     = (QN_W'(b_t_r) >= qn1) ? q_inc : b_q_r;

  assign out_q   = q[PIX_W-1:0];
  assign out_tag = '{vld: b_vld_r, last: b_last_r};

endmodule

// File: src/box_mean_filter_3x3.sv
// ----------------------------------------------------------------------------
// box_mean_filter_3x3
// 3x3 box mean over a raster pixel stream. Pixels are taken in raster order
// and one transaction is accepted every clock cycle while the result side
// keeps up; the rate is set by the line memory, which does one read and one
// write per pixel. The result for pixel (x, y) is produced by the transaction
// that carries raster position (x+1, y+1) and passes through the stage 1,
// window, column sum, divider and output registers, so each frame must be
// followed by frame_width+1 padding transactions whose values are ignored.
// Neighbours outside the frame are left out and the sum is divided by the
// number of neighbours inside, rounded to nearest with ties up. The line
// memory needs no clearing after reset. Writing either frame register
// restarts the frame position and must only be done while the block is idle.
// ----------------------------------------------------------------------------
module box_mean_filter_3x3 #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmf_pkg::PIX_W-1:0]     in_pixel_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bmf_pkg::PIX_W-1:0]     out_mean_out,
  output logic                          out_frame_last,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bmf_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [bmf_pkg::DATA_W-1:0]    cfg_pwdata,
  output logic [bmf_pkg::DATA_W-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  import bmf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int CR_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int PW    = ((CR_W > CFG_W) ? CR_W : CFG_W) + 1;
  localparam int ENT_W = 2 * PIX_W;

  // Configuration and position state
  logic [CFG_W-1:0]     width_r, width_nxt;
  logic [CFG_W-1:0]     height_r, height_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;

  // Handshake
  logic                 adv;
  logic                 accept;

  // Position arithmetic
  logic [PW-1:0]        cx, cy, w, h, ry;
  logic                 zc;
  win_ctl_t             ctl;

  // Stage 1: pixel waiting for its line memory read
  logic                 s1_vld_r;
  win_ctl_t             s1_ctl_r;
  logic [PIX_W-1:0]     s1_pix_r;
  logic [COL_W-1:0]     s1_addr_r;
  logic                 s1_fwd_r;
  logic [ENT_W-1:0]     s1_fwd_data_r;
  logic [ENT_W-1:0]     ram_rdata;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ent;
  logic                 ram_we;
  pix_col_t             new_col;

  // Stage 2: window registers
  pix_col_t             win_r [3];
  logic                 s2_vld_r;
  win_ctl_t             s2_ctl_r;
  logic [CS_W-1:0]      cs [3];

  // Stage 3: column sums
  logic                 s3_vld_r;
  win_ctl_t             s3_ctl_r;
  logic [CS_W-1:0]      s3_cs_r [3];
  logic [1:0]           rows, cols;
  logic [N_W-1:0]       n_cnt;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     t_val;
  div_tag_t             s3_tag;

  // Divider and output register
  div_tag_t             d_tag;
  logic [PIX_W-1:0]     d_q;
  logic                 out_vld_r;
  logic [PIX_W-1:0]     out_mean_r;
  logic                 out_last_r;

  // The whole pipeline moves whenever the output register can take a result.
  assign adv      = !out_vld_r || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && adv;

  // Configuration port decode
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[PADDR_W-1:2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  width_nxt  = clamp_dim(cfg_pwdata[CFG_W-1:0], MAX_WIDTH);
        REG_FRAME_HEIGHT: height_nxt = clamp_dim(cfg_pwdata[CFG_W-1:0], MAX_HEIGHT);
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_FRAME_HEIGHT: cfg_prdata = DATA_W'(height_r);
    endcase
  end

  // Raster position of the next transaction, padding included
  assign cx = PW'(col_r);
  assign cy = PW'(row_r);
  assign w  = PW'(width_r);
  assign h  = PW'(height_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (cy >= h + PW'(1)) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (cx + PW'(1) >= w) begin
        col_nxt = '0;
        row_nxt = row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= clamp_dim(DIM_RESET, MAX_WIDTH);
      height_r <= clamp_dim(DIM_RESET, MAX_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  // Window control. ry is the row of the bottom window line; at the start of
  // a row the window still covers the last column of the row before, and at
  // the very first position ry wraps to a large value and nothing is emitted.
  assign zc = (col_r == '0);
  assign ry = cy - PW'(zc);

  always_comb begin
    ctl.emit     = (ry >= PW'(1)) && (ry <= h);
    ctl.top_ok   = (ry >= PW'(2));
    ctl.bot_ok   = (ry < h);
    ctl.right_ok = !zc;
    ctl.left_ok  = zc ? (w >= PW'(2)) : (cx >= PW'(2));
    ctl.last     = zc && (ry == h);
  end

  // Line memory: each entry holds the two previous lines at one column,
  // the newer line in the upper half.
  assign ram_we    = s1_vld_r && adv;
  assign ent       = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign ram_wdata = {s1_pix_r, ent[ENT_W-1:PIX_W]};
  assign new_col   = '{top: ent[PIX_W-1:0], mid: ent[ENT_W-1:PIX_W], bot: s1_pix_r};

  bmf_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  // Stage 1 registers. A one-pixel-wide frame reads the entry that is being
  // written in the same cycle, so the write data is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ctl_r      <= ctl;
      s1_pix_r      <= in_pixel_in;
      s1_addr_r     <= col_r;
      s1_fwd_r      <= s1_vld_r && (s1_addr_r == col_r);
      s1_fwd_data_r <= ram_wdata;
    end
  end

  // Stage 2: shift the new column into the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r <= s1_ctl_r;
      if (s1_vld_r) begin
        win_r[2] <= win_r[1];
        win_r[1] <= win_r[0];
        win_r[0] <= new_col;
      end
    end
  end

  // Column sums with the lines outside the frame left out
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cs[j] = (s2_ctl_r.top_ok ? CS_W'(win_r[j].top) : '0) + CS_W'(win_r[j].mid)
            + (s2_ctl_r.bot_ok ? CS_W'(win_r[j].bot) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ctl_r <= s2_ctl_r;
      for (int j = 0; j < 3; j++) begin
        s3_cs_r[j] <= cs[j];
      end
    end
  end

  // Window sum, neighbour count and the rounding half
  always_comb begin
    rows  = 2'd1 + 2'(s3_ctl_r.top_ok) + 2'(s3_ctl_r.bot_ok);
    cols  = 2'd1 + 2'(s3_ctl_r.left_ok) + 2'(s3_ctl_r.right_ok);
    n_cnt = N_W'(rows) * N_W'(cols);
    sum   = (s3_ctl_r.left_ok ? SUM_W'(s3_cs_r[2]) : '0) + SUM_W'(s3_cs_r[1])
          + (s3_ctl_r.right_ok ? SUM_W'(s3_cs_r[0]) : '0);
    t_val = sum + SUM_W'(n_cnt >> 1);
  end

  assign s3_tag = '{vld: s3_vld_r, last: s3_ctl_r.last};

  bmf_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_tag  (s3_tag),
    .in_t    (t_val),
    .in_n    (n_cnt),
    .out_tag (d_tag),
    .out_q   (d_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= d_tag.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mean_r <= d_q;
      out_last_r <= d_tag.last;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_mean_out   = out_mean_r;
  assign out_frame_last = out_last_r;

endmodule

// File: src/bmf_chk.sv
// ----------------------------------------------------------------------------
// bmf_chk
// Port-level checks for the 3x3 box mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_chk #(
  parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bmf_pkg::PIX_W-1:0]    out_mean_out,
  input logic                         out_frame_last,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic [bmf_pkg::PADDR_W-1:0]  cfg_paddr,
  input logic [bmf_pkg::DATA_W-1:0]   cfg_pwdata,
  input logic [bmf_pkg::DATA_W-1:0]   cfg_prdata
);

  import bmf_pkg::*;

  // A stalled result transaction holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mean_out)
                                && $stable(out_frame_last))
    else $error("result changed while stalled");

  // With the output register empty the block always takes a transaction.
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused while output is empty");

  // No result is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // A legal frame width reads back as written while the width is addressed.
  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == '0)
    && (cfg_pwdata[CFG_W-1:0] != '0) && (cfg_pwdata[CFG_W-1:0] <= MAX_WIDTH)
    |=> (cfg_paddr[PADDR_W-1:2] != REG_FRAME_WIDTH)
        || (cfg_prdata[CFG_W-1:0] == $past(cfg_pwdata[CFG_W-1:0])))
    else $error("frame width read back wrongly");

endmodule

bind box_mean_filter_3x3 bmf_chk #(
  .MAX_WIDTH (MAX_WIDTH)
) u_bmf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mean_out   (out_mean_out),
  .out_frame_last (out_frame_last),
  .cfg_psel       (cfg_psel),
  .cfg_penable    (cfg_penable),
  .cfg_pwrite     (cfg_pwrite),
  .cfg_paddr      (cfg_paddr),
  .cfg_pwdata     (cfg_pwdata),
  .cfg_prdata     (cfg_prdata)
);

// File: tb/sv/box_mean_filter_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_tb
// Self-checking bench for the 3x3 box mean filter. Frames of pixels and their
// padding are streamed in under random burst and stall patterns. A tracker
// class predicts every rounded mean and frame-end flag from its own copy of
// the pixel history, frame size and raster position, and compares each
// output transaction in order. Frame sizes are changed over the register port
// between phases, taking in zero and saturated settings.
// ----------------------------------------------------------------------------
module box_mean_filter_3x3_tb;

  localparam int FRAME_MAX_W   = bmf_pkg::MAX_WIDTH_DEF;
  localparam int FRAME_MAX_H   = bmf_pkg::MAX_HEIGHT_DEF;
  localparam int HIST_DEPTH    = 2 * FRAME_MAX_W + 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int MAX_REPORTS   = 200;
  localparam int SMALL_TARGET  = 1150;

  typedef enum int {
    PIX_RANDOM,
    PIX_FULL,
    PIX_ZERO,
    PIX_TINY,
    PIX_NEAR_MAX,
    PIX_CHECKER
  } pix_mode_t;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SELDOM,
    READY_PERIODIC
  } stall_mode_t;

  typedef struct packed {
    logic [bmf_pkg::PIX_W-1:0] mean;
    logic                      last;
  } box_mean_t;

  // Predicts the filter output for every accepted pixel and holds the means
  // still due on the output side.
  class mean_tracker;
    logic [bmf_pkg::PIX_W-1:0] hist [HIST_DEPTH];
    int                        wr_ptr;
    int                        fw;
    int                        fh;
    int                        col;
    int                        row;
    int                        errors;
    box_mean_t                 means_due [$];

    function new();
      foreach (hist[k]) hist[k] = '0;
      wr_ptr = 0;
      fw     = int'(bmf_pkg::DIM_RESET);
      fh     = int'(bmf_pkg::DIM_RESET);
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function int pending();
      return means_due.size();
    endfunction

    // A register write clamps the dimension and restarts the frame position.
    function void write_dim(logic [bmf_pkg::REG_IDX_W-1:0] idx, logic [31:0] word);
      int d;
      int lim;
      d   = int'(word[bmf_pkg::CFG_W-1:0]);
      lim = (idx == bmf_pkg::REG_FRAME_WIDTH) ? FRAME_MAX_W : FRAME_MAX_H;
      if (d == 0) d = 1;
      if (d > lim) d = lim;
      if (idx == bmf_pkg::REG_FRAME_WIDTH) begin
        fw = d;
      end else begin
        fh = d;
      end
      col = 0;
      row = 0;
    endfunction

    // Take one pixel into the history and work out the mean it releases.
    function void take_pixel(logic [bmf_pkg::PIX_W-1:0] p);
      int          ox;
      int          oy;
      int          nx;
      int          ny;
      int          idx;
      int          dx;
      int          dy;
      int unsigned sum;
      int unsigned n;
      box_mean_t   r;
      wr_ptr       = (wr_ptr + 1 >= HIST_DEPTH) ? 0 : wr_ptr + 1;
      hist[wr_ptr] = p;
      if (col >= 1) begin
        ox = col - 1;
        oy = row - 1;
      end else begin
        ox = fw - 1;
        oy = row - 2;
      end
      if (oy >= 0 && oy < fh) begin
        sum = 0;
        n   = 0;
        for (dy = -1; dy <= 1; dy++) begin
          for (dx = -1; dx <= 1; dx++) begin
            nx = ox + dx;
            ny = oy + dy;
            if (nx >= 0 && nx < fw && ny >= 0 && ny < fh) begin
              idx = wr_ptr - (fw + 1 - dy * fw - dx);
              if (idx < 0) idx += HIST_DEPTH;
              sum += hist[idx];
              n++;
            end
          end
        end
        r.mean = bmf_pkg::PIX_W'((2 * sum + n) / (2 * n));
        r.last = (ox == fw - 1 && oy == fh - 1);
        means_due.push_back(r);
      end
      // Position runs on through the padding, then wraps to a new frame.
      if (row >= fh + 1) begin
        col = 0;
        row = 0;
      end else begin
        col++;
        if (col >= fw) begin
          col = 0;
          row++;
        end
      end
    endfunction

    // Compare one output transaction with the oldest mean due.
    function void check_mean(logic [bmf_pkg::PIX_W-1:0] mean, logic last);
      box_mean_t want;
      if (means_due.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected output, mean_out %0d frame_last %0b",
                   $time, mean, last);
        errors++;
        return;
      end
      want = means_due.pop_front();
      if (mean !== want.mean) begin
        if (errors < MAX_REPORTS)
          $display("%0t: mean_out expected %0d, actual %0d", $time, want.mean, mean);
        errors++;
      end
      if (last !== want.last) begin
        if (errors < MAX_REPORTS)
          $display("%0t: frame_last expected %0b, actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [bmf_pkg::PIX_W-1:0]     in_pixel_in;
  logic                          out_valid;
  logic                          out_ready;
  logic [bmf_pkg::PIX_W-1:0]     out_mean_out;
  logic                          out_frame_last;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [bmf_pkg::PADDR_W-1:0]   cfg_paddr;
  logic [bmf_pkg::DATA_W-1:0]    cfg_pwdata;
  logic [bmf_pkg::DATA_W-1:0]    cfg_prdata;
  logic                          cfg_pready;

  mean_tracker tracker = new();

  int          burst_left  = 0;
  bit          steady_run  = 1'b0;
  int          items_sent  = 0;
  int          hold_reqs   = 0;
  int          hold_taken  = 0;
  int          hold_left   = 0;
  int          mode_left   = 0;
  stall_mode_t stall_mode  = READY_ALWAYS;

  box_mean_filter_3x3 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_in    (in_pixel_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_mean_out   (out_mean_out),
    .out_frame_last (out_frame_last),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: a stall pattern that changes every so often, and a long
  // hold-off whenever the sender asks for one.
  always @(negedge clk) begin
    if (hold_taken != hold_reqs) begin
      hold_taken = hold_reqs;
      hold_left  = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(32, 256);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else begin
      case (stall_mode)
        READY_ALWAYS: out_ready = 1'b1;
        READY_MOSTLY: out_ready = ($urandom_range(0, 3) != 0);
        READY_SELDOM: out_ready = ($urandom_range(0, 3) == 0);
        default:      out_ready = (mode_left % 5 != 0);
      endcase
    end
  end

  // Every output transaction is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker.check_mean(out_mean_out, out_frame_last);
    end
  end

  // Offer one pixel, in bursts with random gaps between them.
  task automatic send_pixel(input logic [bmf_pkg::PIX_W-1:0] p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if (!steady_run && $urandom_range(0, 2) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid    = 1'b1;
    in_pixel_in = p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_pixel(p);
    @(negedge clk);
  endtask

  // Stop offering and wait until every due mean has come out.
  task automatic settle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [bmf_pkg::REG_IDX_W-1:0] idx, input logic [31:0] word);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = word;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.write_dim(idx, word);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic cfg_read(input logic [bmf_pkg::REG_IDX_W-1:0] idx, output logic [31:0] word);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    word = cfg_prdata;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Register word for a dimension; the bits above the field are sometimes
  // filled with noise.
  function automatic logic [31:0] dim_word(input int raw);
    logic [31:0] word;
    word = $urandom;
    if ($urandom_range(0, 2) != 0) word[31:bmf_pkg::CFG_W] = '0;
    word[bmf_pkg::CFG_W-1:0] = raw[bmf_pkg::CFG_W-1:0];
    return word;
  endfunction

  function automatic logic [bmf_pkg::PIX_W-1:0] pick_pixel(input pix_mode_t mode, input int i);
    case (mode)
      PIX_FULL:     return '1;
      PIX_ZERO:     return '0;
      PIX_TINY:     return bmf_pkg::PIX_W'($urandom_range(0, 3));
      PIX_NEAR_MAX: return bmf_pkg::PIX_W'(16'hFFFF - $urandom_range(0, 3));
      PIX_CHECKER:  return (i % 2 != 0) ? '1 : '0;
      default:      return bmf_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // One frame and its padding; a cut frame stops at a random point.
  task automatic send_frame(input pix_mode_t mode, input bit cut, input int hold_at);
    int pix_count;
    int total;
    int stop_at;
    int i;
    pix_count = tracker.fw * tracker.fh;
    total     = pix_count + tracker.fw + 1;
    stop_at   = cut ? $urandom_range(1, total - 1) : total;
    for (i = 0; i < stop_at; i++) begin
      if (i == hold_at) hold_reqs++;
      items_sent++;
      if (i < pix_count) begin
        send_pixel(pick_pixel(mode, i));
      end else begin
        send_pixel(bmf_pkg::PIX_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int raw_w, input int raw_h, input bit wr_w, input bit wr_h,
                           input int frames, input pix_mode_t mode, input bit cut,
                           input int hold_at);
    int f;
    settle();
    if (wr_w) cfg_write(bmf_pkg::REG_FRAME_WIDTH, dim_word(raw_w));
    if (wr_h) cfg_write(bmf_pkg::REG_FRAME_HEIGHT, dim_word(raw_h));
    for (f = 0; f < frames; f++) begin
      send_frame(mode, cut && (f == frames - 1), hold_at);
    end
  endtask

  // Mostly small frames, some wide-and-flat or narrow-and-tall ones.
  task automatic random_phase();
    int sel;
    int w;
    int h;
    bit ww;
    bit wh;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 10);
    end else if (sel < 9) begin
      w = $urandom_range(11, 40);
      h = $urandom_range(1, 3);
    end else begin
      w = $urandom_range(1, 3);
      h = $urandom_range(11, 40);
    end
    if ($urandom_range(0, 7) == 0) w = 0;
    if ($urandom_range(0, 7) == 0) h = 0;
    ww = 1'b1;
    wh = 1'b1;
    case ($urandom_range(0, 3))
      0:       ww = 1'b0;
      1:       wh = 1'b0;
      default: ;
    endcase
    // Never leave a large dimension in place from an earlier phase.
    if (tracker.fw > 40 || tracker.fh > 40) begin
      ww = 1'b1;
      wh = 1'b1;
    end
    steady_run = ($urandom_range(0, 3) == 0);
    run_phase(w, h, ww, wh, $urandom_range(1, 3), pix_mode_t'($urandom_range(0, 4)),
              ($urandom_range(0, 7) == 0), -1);
  endtask

  // Run time limit.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [31:0] rd;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    out_ready   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Both frame dimensions read back their reset value.
    cfg_read(bmf_pkg::REG_FRAME_WIDTH, rd);
    if (rd[bmf_pkg::CFG_W-1:0] !== bmf_pkg::DIM_RESET) begin
      $display("%0t: frame_width expected %0d, actual %0d", $time, bmf_pkg::DIM_RESET,
               rd[bmf_pkg::CFG_W-1:0]);
      tracker.errors++;
    end
    cfg_read(bmf_pkg::REG_FRAME_HEIGHT, rd);
    if (rd[bmf_pkg::CFG_W-1:0] !== bmf_pkg::DIM_RESET) begin
      $display("%0t: frame_height expected %0d, actual %0d", $time, bmf_pkg::DIM_RESET,
               rd[bmf_pkg::CFG_W-1:0]);
      tracker.errors++;
    end

    // Directed: zero dimensions taken as one, full-scale checkerboard,
    // a frame cut short and restarted by a write, then thin frames.
    run_phase(0, 0, 1'b1, 1'b1, 1, PIX_FULL, 1'b0, -1);
    run_phase(2, 2, 1'b1, 1'b1, 1, PIX_CHECKER, 1'b0, -1);
    run_phase(3, 2, 1'b1, 1'b1, 1, PIX_RANDOM, 1'b1, -1);
    run_phase(3, 1, 1'b1, 1'b1, 1, PIX_TINY, 1'b0, -1);
    run_phase(1, 3, 1'b1, 1'b1, 1, PIX_NEAR_MAX, 1'b0, -1);

    // The receiver is held off part way through a frame while the sender
    // keeps offering, so the block fills up and refuses input.
    steady_run = 1'b0;
    run_phase(10, 10, 1'b1, 1'b1, 1, PIX_RANDOM, 1'b0, 20);

    // Out-of-range dimensions saturate to the limits.
    settle();
    cfg_write(bmf_pkg::REG_FRAME_WIDTH, dim_word(2047));
    cfg_write(bmf_pkg::REG_FRAME_HEIGHT, dim_word(1025));
    cfg_read(bmf_pkg::REG_FRAME_WIDTH, rd);
    if (int'(rd[bmf_pkg::CFG_W-1:0]) != tracker.fw) begin
      $display("%0t: frame_width expected %0d, actual %0d", $time, tracker.fw,
               rd[bmf_pkg::CFG_W-1:0]);
      tracker.errors++;
    end
    cfg_read(bmf_pkg::REG_FRAME_HEIGHT, rd);
    if (int'(rd[bmf_pkg::CFG_W-1:0]) != tracker.fh) begin
      $display("%0t: frame_height expected %0d, actual %0d", $time, tracker.fh,
               rd[bmf_pkg::CFG_W-1:0]);
      tracker.errors++;
    end

    while (items_sent < SMALL_TARGET) random_phase();

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
